// ===== rtl/ual_pkg.sv =====
// ---------------------------------------------------------------------------
// Unordered array list - shared definitions
// Operation codes, field widths and stream bus widths for the list unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ual_pkg;

   // Default number of list entries
   localparam int DEFAULT_CAPACITY = 32;

   // Field widths
   localparam int KIND_W  = 3;
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 5;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 6;

   // Stream bus widths, tdata padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 1;

   // Operation codes carried in the request kind field
   localparam logic [KIND_W-1:0] OP_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] OP_FIND   = 3'd2;
   localparam logic [KIND_W-1:0] OP_READ   = 3'd3;
   localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/unordered_array_list_unit.sv =====
// Sequencing: append, clear and unknown kinds go straight from the request beat
//   to the result stage; read passes through a RAM read wait; find and remove
//   scan the entries in order, reading then comparing each slot; remove with a
//   match then shifts every later entry down one slot before the result.
// One operation at a time; the scan and the compacting shift walk the entry
//   RAM one slot at a time; reset empties the list, not the RAM.
// ---------------------------------------------------------------------------
// Unordered array list unit
// Bounded list of 32-bit words in insertion order, kept in a one-port-read
// RAM. Supports append, remove with compaction, find, indexed read and clear.
// ---------------------------------------------------------------------------
`default_nettype none

module unordered_array_list_unit #(
   parameter int CAPACITY = ual_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // tdata: value[31:0], index[36:32], zeros[39:37]
   input  wire logic [ual_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: kind[2:0]
   input  wire logic [ual_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Result channel
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: position[4:0], read_value[36:5], count[42:37], zeros[47:43]
   output      logic [ual_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: ok[0]
   output      logic [ual_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int MW = (FW > ual_pkg::INDEX_W) ? FW : ual_pkg::INDEX_W;
   localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN_RD   = 3'd1;
   localparam logic [2:0] ST_SCAN_CMP  = 3'd2;
   localparam logic [2:0] ST_SHIFT_RD  = 3'd3;
   localparam logic [2:0] ST_SHIFT_CMP = 3'd4;
   localparam logic [2:0] ST_READ_WAIT = 3'd5;
   localparam logic [2:0] ST_FINISH    = 3'd6;

   // Request fields
   logic [ual_pkg::KIND_W-1:0]  req_kind;
   logic [ual_pkg::WORD_W-1:0]  req_value;
   logic [ual_pkg::INDEX_W-1:0] req_index;

   assign req_kind  = req_tuser[ual_pkg::KIND_W-1:0];
   assign req_value = req_tdata[ual_pkg::WORD_W-1:0];
   assign req_index = req_tdata[ual_pkg::WORD_W +: ual_pkg::INDEX_W];

   // Control registers
   logic [2:0]                 state_ff, state_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [FW-1:0]              ptr_ff, ptr_in;
   logic [FW-1:0]              k_ff, k_in;
   logic                       hit_ff, hit_in;
   logic [FW-1:0]              hit_pos_ff, hit_pos_in;
   logic [ual_pkg::KIND_W-1:0] op_ff, op_in;
   logic [ual_pkg::WORD_W-1:0] key_ff, key_in;
   logic                       res_ok_ff, res_ok_in;
   logic [FW-1:0]              res_pos_ff, res_pos_in;
   logic [ual_pkg::WORD_W-1:0] res_rd_ff, res_rd_in;

   // Result register
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [ual_pkg::POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [ual_pkg::WORD_W-1:0]  rsp_rd_ff, rsp_rd_in;
   logic [ual_pkg::COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // Entry RAM
   logic [ual_pkg::WORD_W-1:0] mem [CAPACITY];
   logic [AW-1:0]              rd_addr;
   logic [ual_pkg::WORD_W-1:0] rd_data_ff;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [ual_pkg::WORD_W-1:0] wr_data;

   logic          accept;
   logic          idx_in_range;
   logic [MW-1:0] idx_ext;
   logic [MW-1:0] fill_ext;
   logic [FW-1:0] ptr_m1;
   logic [FW-1:0] fill_m1;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign idx_ext      = MW'(req_index);
   assign fill_ext     = MW'(fill_ff);
   assign idx_in_range = (idx_ext < fill_ext);
   assign ptr_m1       = ptr_ff - 1'b1;
   assign fill_m1      = fill_ff - 1'b1;

   // Sequencer: scan, shift and result handoff
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      res_ok_in    = res_ok_ff;
      res_pos_in   = res_pos_ff;
      res_rd_in    = res_rd_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = req_value;

      // Drop the result beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_kind;
               key_in     = req_value;
               ptr_in     = '0;
               hit_in     = 1'b0;
               hit_pos_in = '0;
               res_ok_in  = 1'b0;
               res_pos_in = '0;
               res_rd_in  = '0;
               state_in   = ST_FINISH;
               unique case (req_kind)
                  ual_pkg::OP_APPEND: begin
                     if (fill_ff < CAP_F) begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_ff[AW-1:0];
                        fill_in   = fill_ff + 1'b1;
                        res_ok_in = 1'b1;
                     end
                  end
                  ual_pkg::OP_REMOVE, ual_pkg::OP_FIND: begin
                     state_in = ST_SCAN_RD;
                  end
                  ual_pkg::OP_READ: begin
                     res_ok_in = idx_in_range;
                     rd_addr   = idx_in_range ? idx_ext[AW-1:0] : '0;
                     state_in  = ST_READ_WAIT;
                  end
                  ual_pkg::OP_CLEAR: begin
                     res_ok_in = (fill_ff != '0);
                     fill_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            // End of list without a match
            if (ptr_ff == fill_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_addr  = ptr_ff[AW-1:0];
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (rd_data_ff == key_ff) begin
               if (op_ff == ual_pkg::OP_FIND) begin
                  res_ok_in  = 1'b1;
                  res_pos_in = ptr_ff;
                  state_in   = ST_FINISH;
               end else begin
                  k_in     = ptr_ff;
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (ptr_ff == fill_ff) begin
               // Position is what a rescan of the compacted list gives, tracked during the shift
               fill_in   = fill_m1;
               res_ok_in = 1'b1;
               if (hit_ff) begin
                  res_pos_in = hit_pos_ff;
               end else if (k_ff == fill_m1) begin
                  res_pos_in = k_ff;
               end else begin
                  res_pos_in = '0;
               end
               state_in = ST_FINISH;
            end else begin
               rd_addr  = ptr_ff[AW-1:0];
               state_in = ST_SHIFT_CMP;
            end
         end
         ST_SHIFT_CMP: begin
            // Move the entry down one slot, note a later equal entry
            wr_en   = 1'b1;
            wr_addr = ptr_m1[AW-1:0];
            wr_data = rd_data_ff;
            if (!hit_ff && (rd_data_ff == key_ff)) begin
               hit_in     = 1'b1;
               hit_pos_in = ptr_m1;
            end
            ptr_in   = ptr_ff + 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_READ_WAIT: begin
            res_rd_in = res_ok_ff ? rd_data_ff : '0;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // Load the result beat when the output slot is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_pos_in   = ual_pkg::POS_W'(res_pos_ff);
               rsp_rd_in    = res_rd_ff;
               rsp_cnt_in   = ual_pkg::COUNT_W'(fill_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      k_ff       <= k_in;
      hit_ff     <= hit_in;
      hit_pos_ff <= hit_pos_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      res_ok_ff  <= res_ok_in;
      res_pos_ff <= res_pos_in;
      res_rd_ff  <= res_rd_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   // Entry RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {5'd0, rsp_cnt_ff, rsp_rd_ff, rsp_pos_ff};

endmodule

`default_nettype wire

// ===== rtl/ual_checker.sv =====
// ---------------------------------------------------------------------------
// Unordered array list - port checker
// Watches the top level's stream ports for ordering and range slips.
// ---------------------------------------------------------------------------
`default_nettype none

module ual_checker #(
   parameter int CAPACITY = ual_pkg::DEFAULT_CAPACITY
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [ual_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic [ual_pkg::REQ_TUSER_W-1:0] req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ual_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [ual_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   logic [ual_pkg::COUNT_W-1:0] rsp_count;

   assign rsp_count = rsp_tdata[42:37];

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Every operation keeps the unit busy past its request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken in back-to-back cycles");

   // Count never passes the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY >= 64) || (32'(rsp_count) <= CAPACITY))
      else $error("result count above capacity");

   // No result beat right out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat shown after reset");

endmodule

bind unordered_array_list_unit ual_checker #(.CAPACITY(CAPACITY)) u_ual_checker (.*);

`default_nettype wire

// ===== test/unordered_array_list_unit_test.sv =====
// ---------------------------------------------------------------------------
// Unordered array list unit - stream testbench
// Drives list operations on the request stream and checks every response
// beat against a cycle-free model of the list kept in this file. A short
// table of directed operations runs first, then random operations in phases
// with different amounts of sender idling and receiver back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module unordered_array_list_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import ual_pkg::*;

   localparam int LIST_DEPTH = DEFAULT_CAPACITY;
   localparam int PHASE_OPS = 475;
   localparam int DRAIN_CYCLES = 80;

   // Kind codes with no operation behind them
   localparam logic [KIND_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [KIND_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic               ok;
      logic [POS_W-1:0]   position;
      logic [WORD_W-1:0]  read_value;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      int                 reps;
      bit                 typed;
      list_result_type    want;
   } op_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // List model state
   logic [WORD_W-1:0] shadow_words [LIST_DEPTH];
   int unsigned shadow_fill = 0;

   list_result_type pending_results [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   unordered_array_list_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Scan the held entries for the first word equal to the given one
   function automatic int first_slot(input logic [WORD_W-1:0] word, output bit hit);
      int k;
      hit = 1'b0;
      for (k = 0; k < shadow_fill; k++) begin
         if (shadow_words[k] == word) begin
            hit = 1'b1;
            return k;
         end
      end
      return 0;
   endfunction

   // Apply one operation to the list model and return its response
   function automatic list_result_type apply_list_op(input logic [KIND_W-1:0] kind,
                                                     input logic [WORD_W-1:0] value,
                                                     input logic [INDEX_W-1:0] index);
      list_result_type res;
      bit hit;
      int k;
      int slot;
      res = '0;
      case (kind)
         OP_APPEND: begin
            if (shadow_fill < LIST_DEPTH) begin
               shadow_words[shadow_fill] = value;
               shadow_fill++;
               res.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            slot = first_slot(value, hit);
            if (hit) begin
               // close the gap; the old last slot keeps its word
               for (k = slot; k + 1 < shadow_fill; k++)
                  shadow_words[k] = shadow_words[k + 1];
               // position is the first match in the shifted list, fill not yet lowered
               slot = first_slot(value, hit);
               res.position = slot[POS_W-1:0];
               shadow_fill--;
               res.ok = 1'b1;
            end
         end
         OP_FIND: begin
            slot = first_slot(value, hit);
            if (hit) begin
               res.position = slot[POS_W-1:0];
               res.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (index < shadow_fill) begin
               res.read_value = shadow_words[index];
               res.ok = 1'b1;
            end
         end
         OP_CLEAR: begin
            if (shadow_fill != 0) begin
               shadow_fill = 0;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.count = shadow_fill[COUNT_W-1:0];
      return res;
   endfunction

   // Present one request beat, hold it until taken, then maybe go idle
   task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                           input logic [INDEX_W-1:0] index, input bit typed,
                           input list_result_type want);
      list_result_type predicted;
      req_tuser <= kind;
      req_tdata <= {{(REQ_TDATA_W - WORD_W - INDEX_W){1'b0}}, index, value};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(kind, value, index);
      pending_results.push_back(typed ? want : predicted);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Hold off new requests until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Word for a random operation: often one already held, else pool, extreme or any
   function automatic logic [WORD_W-1:0] pick_word(input int held_pct);
      int r;
      r = $urandom_range(99);
      if (shadow_fill != 0 && r < held_pct)
         return shadow_words[$urandom_range(shadow_fill - 1)];
      if (r < held_pct + 15)
         return WORD_W'($urandom_range(7));
      if (r < held_pct + 20)
         return $urandom_range(1) ? '1 : '0;
      return $urandom();
   endfunction

   task automatic random_op(output logic [KIND_W-1:0] kind, output logic [WORD_W-1:0] value,
                            output logic [INDEX_W-1:0] index);
      int r;
      r = $urandom_range(99);
      value = pick_word(10);
      index = INDEX_W'($urandom_range(31));
      if (r < 40) begin
         kind = OP_APPEND;
      end else if (r < 52) begin
         kind = OP_REMOVE;
         value = pick_word(75);
      end else if (r < 70) begin
         kind = OP_FIND;
         value = pick_word(75);
      end else if (r < 97) begin
         kind = OP_READ;
         if (shadow_fill != 0 && $urandom_range(99) < 70)
            index = INDEX_W'($urandom_range(shadow_fill - 1));
      end else if (r < 98) begin
         kind = OP_CLEAR;
      end else begin
         kind = KIND_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
   endtask

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Check each response beat against the oldest expectation; drive back-pressure
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected response beat, expected none, got %h ok %b",
                     $time, rsp_tdata, rsp_tuser[0]);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("ok", WORD_W'(want.ok), WORD_W'(rsp_tuser[0]));
            compare_field("position", WORD_W'(want.position), WORD_W'(rsp_tdata[4:0]));
            compare_field("read_value", want.read_value, rsp_tdata[36:5]);
            compare_field("count", WORD_W'(want.count), WORD_W'(rsp_tdata[42:37]));
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Stimulus
   initial begin
      op_row_type plan [];
      int send_pcts [4];
      int recv_pcts [4];
      int row;
      int rep;
      int phase;
      int n;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value;
      logic [INDEX_W-1:0] index;

      plan = '{
         // empty list: every lookup fails
         '{OP_READ,        32'h0000_0000, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         '{OP_FIND,        32'hFFFF_FFFF, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         '{OP_REMOVE,      32'h0000_0000, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         '{OP_CLEAR,       32'h0000_0000, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         // unused kinds do nothing
         '{OP_SPARE_FIRST, 32'hFFFF_FFFF, 5'd31, 1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         '{OP_SPARE_MID,   32'h0000_0000, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         '{OP_SPARE_LAST,  32'hFFFF_FFFF, 5'd31, 1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd0}},
         // extremes of the word
         '{OP_APPEND,      32'h0000_0000, 5'd0,  1, 1'b1, '{1'b1, 5'd0, 32'h0, 6'd1}},
         '{OP_APPEND,      32'hFFFF_FFFF, 5'd31, 1, 1'b1, '{1'b1, 5'd0, 32'h0, 6'd2}},
         '{OP_FIND,        32'hFFFF_FFFF, 5'd0,  1, 1'b1, '{1'b1, 5'd1, 32'h0, 6'd2}},
         '{OP_READ,        32'h0000_0000, 5'd1,  1, 1'b1, '{1'b1, 5'd0, 32'hFFFF_FFFF, 6'd2}},
         // read past the count
         '{OP_READ,        32'h0000_0000, 5'd31, 1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd2}},
         '{OP_READ,        32'h0000_0000, 5'd2,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd2}},
         '{OP_FIND,        32'h0000_0001, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd2}},
         '{OP_REMOVE,      32'h0000_0000, 5'd0,  1, 1'b0, '0},
         '{OP_READ,        32'h0000_0000, 5'd0,  1, 1'b0, '0},
         '{OP_CLEAR,       32'h0000_0000, 5'd0,  1, 1'b1, '{1'b1, 5'd0, 32'h0, 6'd0}},
         // fill to capacity, then append once more
         '{OP_APPEND,      32'hA5A5_0000, 5'd0,  LIST_DEPTH, 1'b0, '0},
         '{OP_APPEND,      32'hDEAD_BEEF, 5'd0,  1, 1'b1, '{1'b0, 5'd0, 32'h0, 6'd32}},
         '{OP_READ,        32'h0000_0000, 5'd31, 1, 1'b0, '0},
         '{OP_FIND,        32'hA5A5_001F, 5'd0,  1, 1'b0, '0},
         '{OP_REMOVE,      32'hA5A5_0000, 5'd0,  1, 1'b0, '0},
         '{OP_REMOVE,      32'hA5A5_001F, 5'd0,  1, 1'b0, '0},
         '{OP_CLEAR,       32'h0000_0000, 5'd0,  1, 1'b1, '{1'b1, 5'd0, 32'h0, 6'd0}},
         // duplicates: remove takes the first, find then sees the second
         '{OP_APPEND,      32'h0000_0007, 5'd0,  1, 1'b0, '0},
         '{OP_APPEND,      32'h0000_0009, 5'd0,  1, 1'b0, '0},
         '{OP_APPEND,      32'h0000_0007, 5'd0,  1, 1'b0, '0},
         '{OP_REMOVE,      32'h0000_0007, 5'd0,  1, 1'b0, '0},
         '{OP_FIND,        32'h0000_0007, 5'd0,  1, 1'b0, '0}
      };
      send_pcts = '{0, 77, 0, 25};
      recv_pcts = '{0, 0, 77, 25};

      // Reset
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, no idling
      for (row = 0; row < plan.size(); row++) begin
         for (rep = 0; rep < plan[row].reps; rep++)
            issue_op(plan[row].kind, plan[row].value + WORD_W'(rep), plan[row].index,
                     plan[row].typed, plan[row].want);
      end
      drain_responses();

      // Random operations, one idling pattern per phase
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pcts[phase];
         recv_stall_pct = recv_pcts[phase];
         for (n = 0; n < PHASE_OPS; n++) begin
            random_op(kind, value, index);
            issue_op(kind, value, index, 1'b0, '0);
         end
         drain_responses();
      end

      // Let any stray beat show up
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t ns: %0d responses still outstanding, expected 0", $time,
                  pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ual_pkg.sv
rtl/unordered_array_list_unit.sv
rtl/ual_checker.sv
test/unordered_array_list_unit_test.sv
